### design/rectangle_canvas_painter_macros.svh
// Assertion macros shared by the rectangle canvas painter RTL.
`ifndef RECTANGLE_CANVAS_PAINTER_MACROS_SVH
`define RECTANGLE_CANVAS_PAINTER_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define RCP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define RCP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### design/rcp_pkg.sv
// Shared constants, codes and control types of the rectangle canvas painter.
package rcp_pkg;

   // Canvas geometry
   localparam int MAX_SIDE   = 256;
   localparam int SIDE_BITS  = $clog2(MAX_SIDE);
   localparam int ADDR_BITS  = 2 * SIDE_BITS;
   localparam int CELLS      = MAX_SIDE * MAX_SIDE;

   // Field widths
   localparam int CFG_BITS       = 9;
   localparam int CHAR_BITS      = 8;
   localparam int COORD_BITS     = 24;
   localparam int FRAC_BITS      = 8;
   localparam int ONE_UNIT       = 1 << FRAC_BITS;
   localparam int BOUND_BITS     = COORD_BITS + 1 - FRAC_BITS;
   localparam int POS_BITS       = 8;
   localparam int CMD_BITS       = 2;
   localparam int STATUS_BITS    = 2;
   localparam int REG_INDEX_BITS = 2;
   localparam int REQ_DATA_BITS  = 128;
   localparam int RSP_DATA_BITS  = 8;

   // Request word layout (tdata), lowest bit first
   localparam int FILLED_LSB = 0;
   localparam int X_LSB      = FILLED_LSB + 1;
   localparam int Y_LSB      = X_LSB + COORD_BITS;
   localparam int W_LSB      = Y_LSB + COORD_BITS;
   localparam int H_LSB      = W_LSB + COORD_BITS;
   localparam int PCH_LSB    = H_LSB + COORD_BITS;
   localparam int RCOL_LSB   = PCH_LSB + CHAR_BITS;
   localparam int RROW_LSB   = RCOL_LSB + POS_BITS;

   // Commands
   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_DRAW  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd2;

   // Status codes
   localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_REJECT = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_RANGE  = 2'd2;

   // Register indexes
   localparam logic [REG_INDEX_BITS-1:0] REG_WIDTH      = 2'd0;
   localparam logic [REG_INDEX_BITS-1:0] REG_HEIGHT     = 2'd1;
   localparam logic [REG_INDEX_BITS-1:0] REG_BACKGROUND = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic capture;      // latch request word, clear sweep counters
      logic load_bounds;  // register cell bounds of the rectangle
      logic sweep;        // visit one cell, step counters
      logic mem_rd;       // read the requested cell
      logic load_rsp;     // load the response register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [CMD_BITS-1:0] cmd;
      logic                reject;
      logic                read_oob;
      logic                sweep_last;
   } dp_stat_type;

endpackage

### design/rcp_ctrl.sv
// Controller state machine of the rectangle canvas painter.
module rcp_ctrl
   import rcp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SWEEP  = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   // Response register can take a new word
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.load_bounds = 1'b1;
            priority if (stat.cmd == CMD_CLEAR) begin
               state_in = S_SWEEP;
            end else if (stat.cmd == CMD_DRAW) begin
               state_in = stat.reject ? S_FINISH : S_SWEEP;
            end else if (stat.cmd == CMD_READ) begin
               cmd.mem_rd = !stat.read_oob;
               state_in   = stat.read_oob ? S_FINISH : S_READ;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_FINISH;
            end
         end
         S_READ: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output valid: load wins over drain
   always_comb begin
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/rcp_dpath.sv
// Datapath of the rectangle canvas painter: registers, bounds, sweep and canvas memory.
module rcp_dpath
   import rcp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   input  logic [CMD_BITS-1:0]       req_tuser,
   input  logic                      csr_valid,
   input  logic [REG_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata,
   input  ctrl_cmd_type              cmd,
   output dp_stat_type               stat,
   output logic [STATUS_BITS-1:0]    rsp_status,
   output logic [CHAR_BITS-1:0]      rsp_char
);

   // Configuration
   logic [CFG_BITS-1:0]  width_ff, height_ff;
   logic [CHAR_BITS-1:0] bg_ff;

   // Latched request
   logic [CMD_BITS-1:0]          cmd_ff;
   logic                         fill_ff;
   logic signed [COORD_BITS-1:0] x_ff, y_ff, w_ff, h_ff;
   logic [CHAR_BITS-1:0]         pch_ff;
   logic [POS_BITS-1:0]          rcol_ff, rrow_ff;

   // Cell bounds of the rectangle
   logic signed [BOUND_BITS-1:0] cmin_ff, cmax_ff, rmin_ff, rmax_ff;
   logic signed [COORD_BITS:0]   x_up, x_end, y_up, y_end;

   // Sweep counters
   logic [SIDE_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic [SIDE_BITS-1:0] last_col, last_row;

   // Memory and response
   logic [CHAR_BITS-1:0]    canvas_mem [0:CELLS-1];
   logic [CHAR_BITS-1:0]    rd_data_ff;
   logic [STATUS_BITS-1:0]  status_ff, status_in;
   logic [CHAR_BITS-1:0]    char_ff, char_in;

   logic signed [BOUND_BITS-1:0] col_s, row_s;
   logic                         covered, on_edge, mem_we;
   logic [CHAR_BITS-1:0]         wr_char;
   logic [ADDR_BITS-1:0]         wr_addr, rd_addr;

   // Index of the last column or row in use, side clamped to 1..MAX_SIDE
   function automatic logic [SIDE_BITS-1:0] side_last(input logic [CFG_BITS-1:0] side);
      logic [CFG_BITS-1:0] dec;
      dec = side - CFG_BITS'(1);
      priority if (side == '0) begin
         return '0;
      end else if (side > CFG_BITS'(MAX_SIDE)) begin
         return SIDE_BITS'(MAX_SIDE - 1);
      end else begin
         return dec[SIDE_BITS-1:0];
      end
   endfunction

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_BITS'(1);
         height_ff <= CFG_BITS'(1);
         bg_ff     <= CHAR_BITS'(32);
      end else if (csr_valid) begin
         if (csr_index == REG_WIDTH) begin
            width_ff <= csr_wdata;
         end
         if (csr_index == REG_HEIGHT) begin
            height_ff <= csr_wdata;
         end
         if (csr_index == REG_BACKGROUND) begin
            bg_ff <= csr_wdata[CHAR_BITS-1:0];
         end
      end
   end

   assign last_col = side_last(width_ff);
   assign last_row = side_last(height_ff);

   // Request word capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_tuser;
         fill_ff <= req_tdata[FILLED_LSB];
         x_ff    <= req_tdata[X_LSB +: COORD_BITS];
         y_ff    <= req_tdata[Y_LSB +: COORD_BITS];
         w_ff    <= req_tdata[W_LSB +: COORD_BITS];
         h_ff    <= req_tdata[H_LSB +: COORD_BITS];
         pch_ff  <= req_tdata[PCH_LSB +: CHAR_BITS];
         rcol_ff <= req_tdata[RCOL_LSB +: POS_BITS];
         rrow_ff <= req_tdata[RROW_LSB +: POS_BITS];
      end
   end

   // Cell bounds: first cell is ceil(edge), last cell is floor(edge + size)
   assign x_up  = {x_ff[COORD_BITS-1], x_ff} + (COORD_BITS+1)'(ONE_UNIT - 1);
   assign x_end = {x_ff[COORD_BITS-1], x_ff} + {w_ff[COORD_BITS-1], w_ff};
   assign y_up  = {y_ff[COORD_BITS-1], y_ff} + (COORD_BITS+1)'(ONE_UNIT - 1);
   assign y_end = {y_ff[COORD_BITS-1], y_ff} + {h_ff[COORD_BITS-1], h_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_bounds) begin
         cmin_ff <= x_up[COORD_BITS:FRAC_BITS];
         cmax_ff <= x_end[COORD_BITS:FRAC_BITS];
         rmin_ff <= y_up[COORD_BITS:FRAC_BITS];
         rmax_ff <= y_end[COORD_BITS:FRAC_BITS];
      end
   end

   // Sweep counters, row-major over the canvas in use
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (cmd.capture) begin
         col_in = '0;
         row_in = '0;
      end else if (cmd.sweep) begin
         if (col_ff == last_col) begin
            col_in = '0;
            row_in = row_ff + SIDE_BITS'(1);
         end else begin
            col_in = col_ff + SIDE_BITS'(1);
         end
      end else begin
         col_in = col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Coverage test of the current cell
   assign col_s   = $signed({{(BOUND_BITS-SIDE_BITS){1'b0}}, col_ff});
   assign row_s   = $signed({{(BOUND_BITS-SIDE_BITS){1'b0}}, row_ff});
   assign covered = (col_s >= cmin_ff) && (col_s <= cmax_ff) &&
                    (row_s >= rmin_ff) && (row_s <= rmax_ff);
   assign on_edge = (col_s == cmin_ff) || (col_s == cmax_ff) ||
                    (row_s == rmin_ff) || (row_s == rmax_ff);

   assign mem_we  = cmd.sweep && ((cmd_ff == CMD_CLEAR) ||
                    ((cmd_ff == CMD_DRAW) && covered && (fill_ff || on_edge)));
   assign wr_char = (cmd_ff == CMD_CLEAR) ? bg_ff : pch_ff;
   assign wr_addr = {row_ff, col_ff};
   assign rd_addr = {SIDE_BITS'(rrow_ff), SIDE_BITS'(rcol_ff)};

   // Canvas memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         canvas_mem[wr_addr] <= wr_char;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_data_ff <= canvas_mem[rd_addr];
      end
   end

   // Status to controller
   assign stat.cmd        = cmd_ff;
   assign stat.reject     = w_ff[COORD_BITS-1] || (w_ff == '0) ||
                            h_ff[COORD_BITS-1] || (h_ff == '0);
   assign stat.read_oob   = ({1'b0, rcol_ff} > {1'b0, last_col}) ||
                            ({1'b0, rrow_ff} > {1'b0, last_row});
   assign stat.sweep_last = (col_ff == last_col) && (row_ff == last_row);

   // Response word
   always_comb begin
      status_in = ST_OK;
      char_in   = '0;
      unique case (cmd_ff)
         CMD_DRAW: begin
            status_in = stat.reject ? ST_REJECT : ST_OK;
         end
         CMD_READ: begin
            status_in = stat.read_oob ? ST_RANGE : ST_OK;
            char_in   = stat.read_oob ? '0 : rd_data_ff;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff <= status_in;
         char_ff   <= char_in;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_char   = char_ff;

endmodule

### design/rectangle_canvas_painter.sv
// Rectangle canvas painter: takes one command word at a time on req_, answers
// one response word per command on rsp_. The canvas is a 64K x 8 memory with
// one write port and one registered read port, addressed by (row, column),
// holding undefined data until a clear; it has no reset pass. A clear or a draw
// sweeps every cell in use, one cell per cycle; a rejected draw, an out-of-range
// read or an unused command skips the sweep, and a read goes through the
// registered memory read. The response register lets a new command start while
// the previous response waits; csr_ is always ready.
`include "rectangle_canvas_painter_macros.svh"
module rectangle_canvas_painter
   import rcp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Command channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // filled, rect_x, rect_y, rect_w, rect_h, paint_char, read_col, read_row, zero pad
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   // command
   input  logic [CMD_BITS-1:0]       req_tuser,
   // Response channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // cell_char
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // status
   output logic [STATUS_BITS-1:0]    rsp_tuser,
   // Register write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [REG_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   assign csr_ready = 1'b1;

   rcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (dp_stat),
      .cmd        (ctrl_cmd)
   );

   rcp_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (ctrl_cmd),
      .stat       (dp_stat),
      .rsp_status (rsp_tuser),
      .rsp_char   (rsp_tdata)
   );

   // A command in work blocks the next one
   `RCP_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "accepted while busy")
   // A response is never loaded over one still waiting
   `RCP_ASSERT_IMP(a_no_rsp_overwrite, ctrl_cmd.load_rsp, !rsp_tvalid || rsp_tready, "response lost")
   // Only a successful read carries a character
   `RCP_ASSERT_IMP(a_char_only_on_read, rsp_tvalid && (rsp_tuser != ST_OK), rsp_tdata == '0, "stray char")

endmodule
